[design/vdu_pkg.sv]
// ----------------------------------------------------------------------------
// vdu_pkg
// Types and constants shared by the vector distance unit modules.
// ----------------------------------------------------------------------------
package vdu_pkg;

  localparam int ELEM_BITS_DEF = 16;
  localparam int ACC_W         = 48;
  localparam int NORM_W        = 43;
  localparam int MODE_W        = 2;
  localparam int JOB_DEPTH     = 4;
  localparam int RES_DEPTH     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_L1   = 2'd0,
    MODE_L2   = 2'd1,
    MODE_DOT  = 2'd2,
    MODE_NORM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_PUSH
  } back_state_t;

  // one finished vector handed from the accumulator to the finisher
  typedef struct packed {
    mode_t                    mode;
    logic signed [ACC_W-1:0]  sum;
    logic [NORM_W-1:0]        norm_a;
    logic [NORM_W-1:0]        norm_b;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

[design/vdu_fifo.sv]
// ----------------------------------------------------------------------------
// vdu_fifo
// Small synchronous queue with combinational head read.
// ----------------------------------------------------------------------------
module vdu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/vdu_front.sv]
// ----------------------------------------------------------------------------
// vdu_front
// Per-element term (abs difference or product) and saturating running sum;
// a finished vector is queued for the back end.
// ----------------------------------------------------------------------------
module vdu_front import vdu_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [MODE_W-1:0]           cfg_data,
  input  logic                        in_valid,
  input  logic signed [ELEM_BITS-1:0] a_elem,
  input  logic signed [ELEM_BITS-1:0] b_elem,
  input  logic                        last,
  input  logic [NORM_W-1:0]           norm_a,
  input  logic [NORM_W-1:0]           norm_b,
  output logic                        job_push,
  output job_t                        job
);

  localparam int EXT_W  = ELEM_BITS + 1;
  localparam int TERM_W = 2 * EXT_W;
  localparam int SUM_W  = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;

  mode_t                    mode;
  logic signed [EXT_W-1:0]  a_ext;
  logic signed [EXT_W-1:0]  b_ext;
  logic signed [EXT_W-1:0]  diff;
  logic signed [EXT_W-1:0]  abs_diff;
  logic signed [EXT_W-1:0]  mul_x;
  logic signed [EXT_W-1:0]  mul_y;
  logic signed [TERM_W-1:0] prod;
  logic signed [TERM_W-1:0] term;

  logic                     s1_valid;
  logic signed [TERM_W-1:0] s1_term;
  logic                     s1_last;
  mode_t                    s1_mode;
  logic [NORM_W-1:0]        s1_norm_a;
  logic [NORM_W-1:0]        s1_norm_b;

  logic signed [ACC_W-1:0]  running_sum;
  logic signed [SUM_W-1:0]  sum_wide;
  logic signed [ACC_W-1:0]  sum_sat;
  logic                     fits;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_L1;
    end else if (cfg_valid) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // term stage
  always_comb begin
    a_ext    = EXT_W'(a_elem);
    b_ext    = EXT_W'(b_elem);
    diff     = a_ext - b_ext;
    abs_diff = diff[EXT_W-1] ? -diff : diff;
    mul_x    = (mode == MODE_L2) ? diff : a_ext;
    mul_y    = (mode == MODE_L2) ? diff : b_ext;
    prod     = mul_x * mul_y;
    term     = (mode == MODE_L1) ? TERM_W'(abs_diff) : prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_term   <= term;
      s1_last   <= last;
      s1_mode   <= mode;
      s1_norm_a <= norm_a;
      s1_norm_b <= norm_b;
    end
  end

  // accumulate stage
  always_comb begin
    sum_wide = SUM_W'(running_sum) + SUM_W'(s1_term);
    fits     = (sum_wide[SUM_W-1:ACC_W-1] == '0) || (sum_wide[SUM_W-1:ACC_W-1] == '1);
    if (fits) begin
      sum_sat = sum_wide[ACC_W-1:0];
    end else if (sum_wide[SUM_W-1]) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (s1_valid) begin
      running_sum <= s1_last ? '0 : sum_sat;
    end
  end

  assign job_push    = s1_valid && s1_last;
  assign job.mode    = s1_mode;
  assign job.sum     = sum_sat;
  assign job.norm_a  = s1_norm_a;
  assign job.norm_b  = s1_norm_b;

endmodule

[design/vdu_back.sv]
// ----------------------------------------------------------------------------
// vdu_back
// Final operation per vector: pass-through, norm combine, or a bit-pair
// integer square root, one step per cycle.
// ----------------------------------------------------------------------------
module vdu_back import vdu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_empty,
  input  job_t                    job,
  output logic                    job_pop,
  input  logic                    res_full,
  output logic                    res_push,
  output logic signed [ACC_W-1:0] result
);

  localparam int NSUM_W = ACC_W + 3;
  localparam logic [ACC_W-1:0] ROOT_START = ACC_W'(1) << (ACC_W - 2);

  back_state_t              state;
  back_state_t              state_next;
  logic [ACC_W-1:0]         rem;
  logic [ACC_W-1:0]         root;
  logic [ACC_W-1:0]         bitpos;
  logic [ACC_W-1:0]         trial;
  logic signed [NSUM_W-1:0] nsum;
  logic signed [ACC_W-1:0]  nsum_sat;
  logic                     start_root;

  always_comb begin
    nsum = NSUM_W'(job.norm_a) + NSUM_W'(job.norm_b) - (NSUM_W'(job.sum) <<< 1);
    if ((nsum[NSUM_W-1:ACC_W-1] == '0) || (nsum[NSUM_W-1:ACC_W-1] == '1)) begin
      nsum_sat = nsum[ACC_W-1:0];
    end else if (nsum[NSUM_W-1]) begin
      nsum_sat = ACC_MIN;
    end else begin
      nsum_sat = ACC_MAX;
    end
    trial = root + bitpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    res_push   = 1'b0;
    start_root = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          if (job.mode == MODE_L2 && !job.sum[ACC_W-1]) begin
            start_root = 1'b1;
            state_next = B_ROOT;
          end else begin
            state_next = B_PUSH;
          end
        end
      end
      B_ROOT: begin
        if (bitpos == '0) begin
          state_next = B_PUSH;
        end
      end
      B_PUSH: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && job_pop) begin
      rem    <= job.sum;
      root   <= '0;
      bitpos <= ROOT_START;
      case (job.mode)
        MODE_L2:   result <= '0;
        MODE_NORM: result <= nsum_sat;
        default:   result <= job.sum;
      endcase
    end else if (state == B_ROOT) begin
      if (bitpos != '0) begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitpos;
        end else begin
          root <= root >> 1;
        end
        bitpos <= bitpos >> 2;
      end else begin
        result <= root;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == B_ROOT) |-> ($onehot(bitpos) || bitpos == '0))
    else $error("root step mask lost its single bit");

  assert property (@(posedge clk) disable iff (rst)
    start_root |=> (state == B_ROOT && root == '0))
    else $error("root did not start from zero");

  assert property (@(posedge clk) disable iff (rst)
    (state == B_PUSH && $past(state) == B_ROOT) |-> !result[ACC_W-1])
    else $error("euclidean result negative");

endmodule

[design/vector_distance_unit.sv]
// ----------------------------------------------------------------------------
// vector_distance_unit
// Streams element pairs and returns one distance per vector, on the element
// marked last: Manhattan (Q8.8), Euclidean with integer root (Q8.8), dot
// product (Q16.16) or squared Euclidean from norms (Q16.16), chosen by the
// mode register, all saturating to 48 signed bits. One pair is taken every
// cycle; the running sum is a two-stage multiply and add pipeline. Finished
// vectors wait in a four-entry job queue for the finisher, which passes the
// sum through in modes 0 and 2, combines the norms in mode 3 and in mode 1
// takes the square root one bit pair per cycle. Input stalls (full) only
// when the job queue fills, i.e. with vectors shorter than 2 elements in
// modes 0, 2 and 3 or shorter than 27 elements in mode 1, or when results
// are not popped. Write the mode only while the unit is idle.
// ----------------------------------------------------------------------------
module vector_distance_unit import vdu_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [MODE_W-1:0]           cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic signed [ELEM_BITS-1:0] a_elem,
  input  logic signed [ELEM_BITS-1:0] b_elem,
  input  logic                        last,
  input  logic [NORM_W-1:0]           norm_a,
  input  logic [NORM_W-1:0]           norm_b,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [ACC_W-1:0]     distance
);

  localparam int JCNT_W = $clog2(JOB_DEPTH + 1);

  logic                    in_valid;
  logic                    job_push;
  job_t                    job_in;
  logic [JOB_W-1:0]        job_raw;
  job_t                    job_out;
  logic                    job_full;
  logic                    job_empty;
  logic                    job_pop;
  logic [JCNT_W-1:0]       job_count;
  logic                    res_push;
  logic                    res_full;
  logic signed [ACC_W-1:0] result;
  logic [ACC_W-1:0]        res_raw;

  assign cfg_ready = 1'b1;
  assign in_valid  = push && !full;
  // one slot held back for a vector still in the accumulate stage
  assign full      = (job_count >= JCNT_W'(JOB_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count <= '0;
    end else begin
      case ({job_push, job_pop})
        2'b10:   job_count <= job_count + 1'b1;
        2'b01:   job_count <= job_count - 1'b1;
        default: job_count <= job_count;
      endcase
    end
  end

  vdu_front #(
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .a_elem    (a_elem),
    .b_elem    (b_elem),
    .last      (last),
    .norm_a    (norm_a),
    .norm_b    (norm_b),
    .job_push  (job_push),
    .job       (job_in)
  );

  vdu_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_raw),
    .empty (job_empty)
  );

  assign job_out = job_t'(job_raw);

  vdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .result    (result)
  );

  vdu_fifo #(
    .WIDTH (ACC_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (result),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_raw),
    .empty (empty)
  );

  assign distance = $signed(res_raw);

  assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    job_count <= JCNT_W'(JOB_DEPTH))
    else $error("job count out of range");

  assert property (@(posedge clk) disable iff (rst)
    job_empty |-> (job_count == '0))
    else $error("job count disagrees with queue");

endmodule
